/* rtl/swmf_pkg.sv */
// ----------------------------------------------------------------------------
// swmf_pkg
// shared constants and types of the sliding window median filter
// ----------------------------------------------------------------------------
package swmf_pkg;

    // default parameter values
    localparam int MAX_HALF_WIDTH_DEFAULT = 7;
    localparam int SAMPLE_BITS_DEFAULT    = 16;

    // half width register
    localparam int HALF_WIDTH_BITS = 3;
    typedef logic [HALF_WIDTH_BITS-1:0] half_width_t;
    localparam half_width_t HALF_WIDTH_RESET = 3'd3;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/swmf_if.sv */
// ----------------------------------------------------------------------------
// swmf interfaces
// valid/ready channels for samples, medians and the half width register
// ----------------------------------------------------------------------------

// sample channel
interface swmf_sample_if #(
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] depth_sample;
    logic                   end_of_sequence;

    modport source (output valid, depth_sample, end_of_sequence, input ready);
    modport sink   (input valid, depth_sample, end_of_sequence, output ready);
endinterface

// median channel
interface swmf_median_if #(
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] median_value;
    logic                   last_result;

    modport source (output valid, median_value, last_result, input ready);
    modport sink   (input valid, median_value, last_result, output ready);
endinterface

// half width register write channel
interface swmf_cfg_if ();
    logic                      valid;
    logic                      ready;
    swmf_pkg::half_width_t     half_width;

    modport source (output valid, half_width, input ready);
    modport sink   (input valid, half_width, output ready);
endinterface

/* rtl/swmf_front.sv */
// ----------------------------------------------------------------------------
// swmf_front
// takes sample beats, tracks the window fill and plans the results per sample
// ----------------------------------------------------------------------------
module swmf_front #(
    parameter int  MAX_HALF_WIDTH = swmf_pkg::MAX_HALF_WIDTH_DEFAULT,
    parameter int  SAMPLE_BITS    = swmf_pkg::SAMPLE_BITS_DEFAULT,
    localparam int HW_BITS        = $clog2(MAX_HALF_WIDTH + 1),
    localparam int FILL_BITS      = HW_BITS + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    swmf_sample_if.sink            samples,
    swmf_cfg_if.sink               cfg,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [SAMPLE_BITS-1:0] push_sample,
    output logic                   push_last,
    output logic                   push_has_jobs,
    output logic [HW_BITS-1:0]     push_start_lag,
    output logic [HW_BITS-1:0]     push_n,
    output logic [FILL_BITS-1:0]   push_fill
);
    import swmf_pkg::*;

    half_width_t            half_width_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic [FILL_BITS-1:0]   fill_next;
    logic [HW_BITS-1:0]     n;
    logic [FILL_BITS-1:0]   cap;
    logic [FILL_BITS-1:0]   kept;
    logic [FILL_BITS-1:0]   new_fill;
    logic                   has_main;
    logic                   accept;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    // clamp the half width to what the store holds
    always_comb
    begin
        if (int'(half_width_reg) > MAX_HALF_WIDTH)
        begin
            n = HW_BITS'(MAX_HALF_WIDTH);
        end
        else
        begin
            n = HW_BITS'(half_width_reg);
        end
    end

    // fill after dropping the oldest entries and appending this sample
    assign cap      = FILL_BITS'({n, 1'b1});
    assign kept     = (fill_reg >= cap) ? cap - 1'b1 : fill_reg;
    assign new_fill = kept + 1'b1;
    assign has_main = new_fill > FILL_BITS'(n);

    // results: lags from min(n, fill-1) down, down to zero on the end marker
    assign push_start_lag = (kept > FILL_BITS'(n)) ? n : HW_BITS'(kept);
    assign push_has_jobs  = has_main || samples.end_of_sequence;
    assign push_sample    = samples.depth_sample;
    assign push_last      = samples.end_of_sequence;
    assign push_n         = n;
    assign push_fill      = new_fill;

    // handshake straight into the queue
    assign push_valid    = samples.valid;
    assign samples.ready = push_ready;
    assign accept        = samples.valid && push_ready;

    // fill count restarts after the end marker
    assign fill_next = samples.end_of_sequence ? '0 : new_fill;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_WIDTH_RESET;
            fill_reg       <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                half_width_reg <= cfg.half_width;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

endmodule

/* rtl/swmf_queue.sv */
// ----------------------------------------------------------------------------
// swmf_queue
// small first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module swmf_queue #(
    parameter int  WIDTH    = 8,
    parameter int  DEPTH    = swmf_pkg::QUEUE_DEPTH,
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0]    slots [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic                push;
    logic                pop;

    // status
    assign push_ready = count_reg != CNT_BITS'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/swmf_back.sv */
// ----------------------------------------------------------------------------
// swmf_back
// holds the sample window and issues one median per cycle by rank selection while the output is not stalled
// ----------------------------------------------------------------------------
module swmf_back #(
    parameter int  MAX_HALF_WIDTH = swmf_pkg::MAX_HALF_WIDTH_DEFAULT,
    parameter int  SAMPLE_BITS    = swmf_pkg::SAMPLE_BITS_DEFAULT,
    localparam int DEPTH          = 2 * MAX_HALF_WIDTH + 1,
    localparam int HW_BITS        = $clog2(MAX_HALF_WIDTH + 1),
    localparam int FILL_BITS      = HW_BITS + 1,
    localparam int RANK_BITS      = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [SAMPLE_BITS-1:0] pop_sample,
    input  logic                   pop_last,
    input  logic                   pop_has_jobs,
    input  logic [HW_BITS-1:0]     pop_start_lag,
    input  logic [HW_BITS-1:0]     pop_n,
    input  logic [FILL_BITS-1:0]   pop_fill,
    swmf_median_if.source          medians
);
    // window, newest sample at entry zero
    logic [SAMPLE_BITS-1:0] win_reg [DEPTH];

    // job sequencer
    logic                   job_active_reg;
    logic                   last_reg;
    logic [HW_BITS-1:0]     lag_reg;
    logic [HW_BITS-1:0]     n_reg;
    logic [FILL_BITS-1:0]   fill_reg;

    // rank stage
    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic [RANK_BITS-1:0]   rank_reg [DEPTH];
    logic [DEPTH-1:0]       in_win_reg;
    logic [SAMPLE_BITS-1:0] snap_reg [DEPTH];
    logic [RANK_BITS-1:0]   lo_rank_reg;
    logic [RANK_BITS-1:0]   hi_rank_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_last_reg;
    logic [SAMPLE_BITS-1:0] out_value_reg;

    logic                   out_adv;
    logic                   s1_free;
    logic                   issue;
    logic                   final_job;
    logic                   item_done;
    logic                   pop;
    logic [FILL_BITS-1:0]   span;
    logic [FILL_BITS-1:0]   k;
    logic [DEPTH-1:0]       in_win_next;
    logic [DEPTH-1:0]       below_vec [DEPTH];
    logic [RANK_BITS-1:0]   rank_next [DEPTH];
    logic [SAMPLE_BITS-1:0] lo_val;
    logic [SAMPLE_BITS-1:0] hi_val;
    logic [SAMPLE_BITS:0]   pair_sum;

    // pipeline flow
    assign out_adv   = !out_valid_reg || medians.ready;
    assign s1_free   = !s1_valid_reg || out_adv;
    assign issue     = job_active_reg && s1_free;
    assign final_job = !last_reg || (lag_reg == '0);
    assign item_done = !job_active_reg || (issue && final_job);
    assign pop_ready = item_done;
    assign pop       = pop_valid && item_done;

    // window size for this lag: newest min(lag + n + 1, fill) entries
    assign span = FILL_BITS'(lag_reg) + FILL_BITS'(n_reg) + 1'b1;
    assign k    = (span < fill_reg) ? span : fill_reg;

    // entries in the window and pairwise order, ties broken by position
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            in_win_next[i] = FILL_BITS'(i) < k;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                below_vec[i][j] = (j != i) && in_win_next[j] &&
                                  ((win_reg[j] < win_reg[i]) ||
                                   ((win_reg[j] == win_reg[i]) && (j < i)));
            end
            rank_next[i] = RANK_BITS'($countones(below_vec[i]));
        end
    end

    // pick the two middle entries and average them
    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (in_win_reg[i] && (rank_reg[i] == lo_rank_reg))
            begin
                lo_val = lo_val | snap_reg[i];
            end
            if (in_win_reg[i] && (rank_reg[i] == hi_rank_reg))
            begin
                hi_val = hi_val | snap_reg[i];
            end
        end
        pair_sum = {1'b0, lo_val} + {1'b0, hi_val};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_active_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_active_reg <= pop_has_jobs;
            end
            else if (issue && final_job)
            begin
                job_active_reg <= 1'b0;
            end
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // window shift and job state
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            win_reg[0] <= pop_sample;
            for (int i = 1; i < DEPTH; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
            last_reg <= pop_last;
            lag_reg  <= pop_start_lag;
            n_reg    <= pop_n;
            fill_reg <= pop_fill;
        end
        else if (issue)
        begin
            lag_reg <= lag_reg - 1'b1;
        end
    end

    // rank stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                rank_reg[i] <= rank_next[i];
                snap_reg[i] <= win_reg[i];
            end
            in_win_reg  <= in_win_next;
            lo_rank_reg <= RANK_BITS'((k - 1'b1) >> 1);
            hi_rank_reg <= RANK_BITS'(k >> 1);
            s1_last_reg <= last_reg && (lag_reg == '0);
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_value_reg <= pair_sum[SAMPLE_BITS:1];
            out_last_reg  <= s1_last_reg;
        end
    end

    assign medians.valid        = out_valid_reg;
    assign medians.median_value = out_value_reg;
    assign medians.last_result  = out_last_reg;

endmodule

/* rtl/sliding_window_median_filter.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// latency: with an empty queue a sample passes the queue, job, rank and output registers to its first median
// throughput: one sample per cycle while each sample gives at most one median and the
// median output is not stalled; an end-of-sequence sample gives up to N+1 medians, one
// per cycle from the rank stage, and the 2-entry queue stalls the input meanwhile
// reset: counters and pipeline cleared, half width set to 3, window not cleared
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
    parameter int MAX_HALF_WIDTH = swmf_pkg::MAX_HALF_WIDTH_DEFAULT,
    parameter int SAMPLE_BITS    = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    swmf_sample_if.sink   samples,
    swmf_cfg_if.sink      cfg,
    swmf_median_if.source medians
);
    import swmf_pkg::*;

    localparam int HW_BITS    = $clog2(MAX_HALF_WIDTH + 1);
    localparam int FILL_BITS  = HW_BITS + 1;
    localparam int ENTRY_BITS = SAMPLE_BITS + 2 + 2 * HW_BITS + FILL_BITS;

    logic                   push_valid;
    logic                   push_ready;
    logic [SAMPLE_BITS-1:0] push_sample;
    logic                   push_last;
    logic                   push_has_jobs;
    logic [HW_BITS-1:0]     push_start_lag;
    logic [HW_BITS-1:0]     push_n;
    logic [FILL_BITS-1:0]   push_fill;
    logic [ENTRY_BITS-1:0]  push_data;

    logic                   pop_valid;
    logic                   pop_ready;
    logic [ENTRY_BITS-1:0]  pop_data;
    logic [SAMPLE_BITS-1:0] pop_sample;
    logic                   pop_last;
    logic                   pop_has_jobs;
    logic [HW_BITS-1:0]     pop_start_lag;
    logic [HW_BITS-1:0]     pop_n;
    logic [FILL_BITS-1:0]   pop_fill;

    // front: classify samples
    swmf_front #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples),
        .cfg            (cfg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_sample    (push_sample),
        .push_last      (push_last),
        .push_has_jobs  (push_has_jobs),
        .push_start_lag (push_start_lag),
        .push_n         (push_n),
        .push_fill      (push_fill)
    );

    // queue entry packing
    assign push_data = {push_sample, push_last, push_has_jobs,
                        push_start_lag, push_n, push_fill};
    assign {pop_sample, pop_last, pop_has_jobs,
            pop_start_lag, pop_n, pop_fill} = pop_data;

    swmf_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: window and median selection
    swmf_back #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_sample    (pop_sample),
        .pop_last      (pop_last),
        .pop_has_jobs  (pop_has_jobs),
        .pop_start_lag (pop_start_lag),
        .pop_n         (pop_n),
        .pop_fill      (pop_fill),
        .medians       (medians)
    );

endmodule

/* rtl/swmf_checker.sv */
// ----------------------------------------------------------------------------
// swmf_checker
// port-level checks of the median filter, bound to the top level
// ----------------------------------------------------------------------------
module swmf_checker #(
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_end,
    input logic                   cfg_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_value,
    input logic                   out_last
);
    localparam int PEND_BITS = 4;

    logic [PEND_BITS-1:0] pend_reg;
    logic [PEND_BITS-1:0] pend_next;
    logic                 end_in;
    logic                 end_out;

    // sequences whose end marker went in but whose last median is not out
    assign end_in  = in_valid && in_ready && in_end;
    assign end_out = out_valid && out_ready && out_last;

    always_comb
    begin
        pend_next = pend_reg;
        if (end_in && !end_out)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (end_out && !end_in)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled median beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
        else $error("median beat changed while stalled");

    // register writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("half width write refused");

    // no median can come out before the pipeline has filled after reset
    a_startup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("median beat too soon after reset");

    // a final median only closes a sequence whose end marker was taken
    a_last_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> pend_reg != '0)
        else $error("final median without an end marker");

endmodule

bind sliding_window_median_filter swmf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_end    (samples.end_of_sequence),
    .cfg_ready (cfg.ready),
    .out_valid (medians.valid),
    .out_ready (medians.ready),
    .out_value (medians.median_value),
    .out_last  (medians.last_result)
);
